// ===== rtl/oec_pkg.sv =====
// Package for the octal escape codec: shared types, character codes and the
// command passed from the front end to the back end. No dependencies.
package oec_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_PRINT_LO  = 8'h20;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7E;
   localparam logic [7:0] CH_NUL       = 8'h00;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_ADDR_W  = 3;
   localparam logic        CSR_IDX_MODE = 1'b0;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef enum logic [1:0] {
      CMD_SINGLE = 2'd0,
      CMD_DOUBLE = 2'd1,
      CMD_OCTAL  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
      logic         err;
   } cmd_type;

   typedef struct packed {
      logic wr;
      logic mode;
   } cfg_wr_type;

endpackage

// ===== rtl/octal_escape_codec.sv =====
// Top level of the octal escape codec: APB register decode and the
// front end, command queue and back end. Uses oec_pkg.
//
// Usage: write mode (register 0, byte address 0) over the csr_ port while
// the block is idle: 0 encodes raw bytes into backslash escaped text, 1
// decodes such text back to bytes. A mode write also clears the decode
// escape state. Requests arrive on req_ (tdata = source byte, tlast = end
// of string); responses leave on rsp_ (tdata = byte, tlast = last byte of
// this request's responses, tuser = decode error).
// An accepted request is written into the command queue; the back end then
// loads its first response byte from the queue head into the output register.
// Throughput: one response byte per cycle while rsp_tready is high; a request
// gives 1 to 4 response bytes, 4 for octal escapes in encode mode. A request
// with no response (in decode, a NUL or a non-final escape byte) is not queued.
// The front end keeps taking requests while the two-entry command queue
// has room, so it runs ahead of a stalled response channel.
// Reset: mode returns to encode, the queue empties, escape state clears.
// When rsp_tready is low the output register holds its byte; the queue
// fills and then req_tready drops.
module octal_escape_codec
   import oec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte[7:0]
   input  logic                  req_tlast,   // end_of_string
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_byte[7:0]
   output logic                  rsp_tlast,   // run_last
   output logic                  rsp_tuser    // error
);

   cfg_wr_type cfg_wr;
   logic       mode;
   logic       q_full, q_empty, q_push, q_pop;
   cmd_type    q_cmd, q_head;

   assign csr_pready = 1'b1;
   assign cfg_wr.wr  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MODE);
   assign cfg_wr.mode = csr_pwdata[0];
   assign csr_prdata  = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MODE) ? {31'b0, mode} : '0;

   oec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_wr     (cfg_wr),
      .mode       (mode),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   oec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   oec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/oec_front.sv =====
// Front end: accepts requests, holds the mode register and the decode escape
// state, and turns each request into a back end command. Uses oec_pkg.
module oec_front
   import oec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_wr_type cfg_wr,
   output logic       mode,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte[7:0]
   input  logic       req_tlast,   // end_of_string
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_SLASH = 4'b0010,
      PH_DIG1  = 4'b0100,
      PH_DIG2  = 4'b1000
   } phase_type;

   logic       mode_ff, mode_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] partial_ff, partial_in;

   logic       accept;
   logic       char_is_num;
   logic [3:0] digit;
   logic       has_rsp;
   logic       dec_err;
   logic [7:0] dec_value;
   cmd_type    enc_cmd;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = !q_full;
   assign mode        = mode_ff;
   assign char_is_num = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign digit       = 4'(req_tdata - CH_ZERO);

   always_comb begin
      enc_cmd.value = req_tdata;
      enc_cmd.err   = 1'b0;
      if (req_tdata == CH_BACKSLASH) begin
         enc_cmd.kind = CMD_DOUBLE;
      end else if (req_tdata >= CH_PRINT_LO && req_tdata <= CH_PRINT_HI
                   && req_tdata != CH_DQUOTE) begin
         enc_cmd.kind = CMD_SINGLE;
      end else begin
         enc_cmd.kind = CMD_OCTAL;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      has_rsp    = 1'b0;
      dec_err    = 1'b0;
      dec_value  = req_tdata;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_tdata == CH_BACKSLASH) begin
               phase_in = PH_SLASH;
            end else if (req_tdata != CH_NUL) begin
               has_rsp = 1'b1;
            end
         end
         PH_SLASH: begin
            if (req_tdata == CH_BACKSLASH) begin
               phase_in = PH_IDLE;
               has_rsp  = 1'b1;
            end else if (char_is_num) begin
               partial_in = {digit[1:0], 6'b0};
               phase_in   = PH_DIG1;
            end else begin
               dec_err = 1'b1;
            end
         end
         PH_DIG1: begin
            if (char_is_num) begin
               partial_in = partial_ff | {1'b0, digit, 3'b0};
               phase_in   = PH_DIG2;
            end else begin
               dec_err = 1'b1;
            end
         end
         PH_DIG2: begin
            if (char_is_num) begin
               dec_value  = partial_ff | {4'b0, digit};
               has_rsp    = 1'b1;
               phase_in   = PH_IDLE;
               partial_in = '0;
            end else begin
               dec_err = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      // truncated escape at end of string
      if (req_tlast && phase_in != PH_IDLE) begin
         dec_err = 1'b1;
      end
      if (dec_err) begin
         phase_in   = PH_IDLE;
         partial_in = '0;
         has_rsp    = 1'b1;
         dec_value  = '0;
      end
   end

   always_comb begin
      if (mode_ff == MODE_DECODE) begin
         q_cmd.kind  = CMD_SINGLE;
         q_cmd.value = dec_value;
         q_cmd.err   = dec_err;
         q_push      = accept && has_rsp;
      end else begin
         q_cmd  = enc_cmd;
         q_push = accept;
      end
   end

   assign mode_in = cfg_wr.wr ? cfg_wr.mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ENCODE;
         phase_ff   <= PH_IDLE;
         partial_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         if (cfg_wr.wr) begin
            phase_ff   <= PH_IDLE;
            partial_ff <= '0;
         end else if (accept && mode_ff == MODE_DECODE) begin
            phase_ff   <= phase_in;
            partial_ff <= partial_in;
         end
      end
   end

endmodule

// ===== rtl/oec_queue.sv =====
// Command queue between front and back end, QUEUE_DEPTH entries.
// Uses oec_pkg for the command type and depth.
module oec_queue
   import oec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/oec_back.sv =====
// Back end: expands queued commands into one to four response bytes, one per
// cycle while rsp_tready allows, into the response output register. Uses oec_pkg.
module oec_back
   import oec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    q_head,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // error
);

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       load;

   assign load  = !q_empty && (!valid_ff || rsp_tready);
   assign q_pop = load && last_in;

   always_comb begin
      err_in = 1'b0;
      unique case (q_head.kind)
         CMD_SINGLE: begin
            data_in = q_head.value;
            last_in = 1'b1;
            err_in  = q_head.err;
         end
         CMD_DOUBLE: begin
            data_in = CH_BACKSLASH;
            last_in = (step_ff == 2'd1);
         end
         CMD_OCTAL: begin
            unique case (step_ff)
               2'd0: data_in = CH_BACKSLASH;
               2'd1: data_in = CH_ZERO | {6'b0, q_head.value[7:6]};
               2'd2: data_in = CH_ZERO | {5'b0, q_head.value[5:3]};
               2'd3: data_in = CH_ZERO | {5'b0, q_head.value[2:0]};
               default: data_in = CH_BACKSLASH;
            endcase
            last_in = (step_ff == 2'd3);
         end
         default: begin
            data_in = q_head.value;
            last_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (load) begin
         step_in = last_in ? 2'd0 : step_ff + 2'd1;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

   a_err_is_last_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("error response not a zero last byte");

   a_step_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 2'd0) |-> (!q_empty && q_head.kind != CMD_SINGLE))
      else $error("expansion step without multi-byte command");

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (load && !last_in) |=> (step_ff == $past(step_ff) + 2'd1))
      else $error("expansion step did not advance");

endmodule

// ===== tb/octal_escape_codec_tb.sv =====
// Testbench for octal_escape_codec: a directed table and random byte streams in both modes.
// Responses are checked against an in-bench predictor or the bytes given by typed table rows.
// Depends on oec_pkg and the octal_escape_codec RTL.
`timescale 1ns / 100ps

module octal_escape_codec_tb;
   import oec_pkg::*;

   localparam int DIR_ROWS        = 28;
   localparam int RAND_PHASES     = 5;
   localparam int ITEMS_PER_PHASE = 17;
   localparam int PRESSURE_CYCLES = 80;
   localparam int SETTLE_CYCLES   = 10;
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = CSR_ADDR_W'(4 * CSR_IDX_MODE);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SLASH  = 2'd1,
      PH_DIGIT1 = 2'd2,
      PH_DIGIT2 = 2'd3
   } esc_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } rsp_item_type;

   // typed rows carry their responses: chars lowest byte first, cnt of them
   typedef struct packed {
      logic        mode;
      logic [7:0]  data;
      logic        eos;
      logic        typed;
      logic [2:0]  cnt;
      logic [31:0] chars;
      logic        err;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // data_byte[7:0]
   logic                  req_tlast = 1'b0; // end_of_string
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // out_byte[7:0]
   logic                  rsp_tlast;        // run_last
   logic                  rsp_tuser;        // error

   logic          cfg_mode = MODE_ENCODE;
   esc_phase_type esc_phase = PH_IDLE;
   logic [7:0]    part_val = '0;

   rsp_item_type pending_bytes [$];
   int        fail_count = 0;
   logic      idle_on = 1'b1;
   logic      pressure_go = 1'b0;
   logic      pressure_hold = 1'b0;
   int        stall_left = 0;

   dir_row_type dir_tab [DIR_ROWS] = '{
      '{MODE_ENCODE, 8'h00, 1'b0, 1'b1, 3'd4, 32'h3030305C, 1'b0},
      '{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 3'd4, 32'h3737335C, 1'b0},
      '{MODE_ENCODE, 8'h5C, 1'b0, 1'b1, 3'd2, 32'h00005C5C, 1'b0},
      '{MODE_ENCODE, 8'h22, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_ENCODE, 8'h20, 1'b0, 1'b1, 3'd1, 32'h00000020, 1'b0},
      '{MODE_ENCODE, 8'h7F, 1'b0, 1'b1, 3'd4, 32'h3737315C, 1'b0},
      '{MODE_ENCODE, 8'h1F, 1'b1, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h5C, 1'b0, 1'b1, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h33, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h37, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h37, 1'b1, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h39, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h39, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h39, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h78, 1'b0, 1'b1, 3'd1, 32'h0,        1'b1},
      '{MODE_DECODE, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h31, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h5A, 1'b0, 1'b1, 3'd1, 32'h0,        1'b1},
      '{MODE_DECODE, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h32, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h30, 1'b0, 1'b0, 3'd0, 32'h0,        1'b0},
      '{MODE_DECODE, 8'h00, 1'b0, 1'b1, 3'd1, 32'h0,        1'b1},
      '{MODE_DECODE, 8'h5C, 1'b1, 1'b1, 3'd1, 32'h0,        1'b1}
   };

   octal_escape_codec DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int flag_bad_escape(output rsp_item_type first);
      esc_phase = PH_IDLE;
      part_val  = '0;
      first     = '{8'h00, 1'b1, 1'b1};
      return 1;
   endfunction

   function automatic int predict_codec(input logic [7:0] b, input logic eos,
                                        output rsp_item_type res [4]);
      logic       digit;
      logic [7:0] d;
      int         n;
      digit = (b >= CH_ZERO) && (b <= CH_NINE);
      d     = b - CH_ZERO;
      n     = 0;
      for (int k = 0; k < 4; k++) res[k] = '0;
      if (cfg_mode == MODE_ENCODE) begin
         if (b == CH_BACKSLASH) begin
            res[0] = '{CH_BACKSLASH, 1'b0, 1'b0};
            res[1] = '{CH_BACKSLASH, 1'b1, 1'b0};
            return 2;
         end
         if (b >= CH_PRINT_LO && b <= CH_PRINT_HI && b != CH_DQUOTE) begin
            res[0] = '{b, 1'b1, 1'b0};
            return 1;
         end
         res[0] = '{CH_BACKSLASH, 1'b0, 1'b0};
         res[1] = '{CH_ZERO + {6'd0, b[7:6]}, 1'b0, 1'b0};
         res[2] = '{CH_ZERO + {5'd0, b[5:3]}, 1'b0, 1'b0};
         res[3] = '{CH_ZERO + {5'd0, b[2:0]}, 1'b1, 1'b0};
         return 4;
      end
      case (esc_phase)
         PH_IDLE: begin
            if (b == CH_NUL) return 0;
            if (b == CH_BACKSLASH) begin
               esc_phase = PH_SLASH;
            end else begin
               res[0] = '{b, 1'b1, 1'b0};
               n = 1;
            end
         end
         PH_SLASH: begin
            if (b == CH_BACKSLASH) begin
               esc_phase = PH_IDLE;
               res[0] = '{CH_BACKSLASH, 1'b1, 1'b0};
               n = 1;
            end else if (digit) begin
               part_val  = d << 6;
               esc_phase = PH_DIGIT1;
            end else begin
               return flag_bad_escape(res[0]);
            end
         end
         PH_DIGIT1: begin
            if (!digit) return flag_bad_escape(res[0]);
            part_val  = part_val | (d << 3);
            esc_phase = PH_DIGIT2;
         end
         default: begin
            if (!digit) return flag_bad_escape(res[0]);
            res[0]    = '{part_val | d, 1'b1, 1'b0};
            esc_phase = PH_IDLE;
            part_val  = '0;
            n = 1;
         end
      endcase
      // string ends with an escape still open
      if (eos && esc_phase != PH_IDLE) return flag_bad_escape(res[0]);
      return n;
   endfunction

   function automatic logic [7:0] pick_digit(input int unsigned top);
      if ($urandom_range(0, 9) == 0) return CH_ZERO + 8'($urandom_range(0, 9));
      return CH_ZERO + 8'($urandom_range(0, top));
   endfunction

   task automatic send_request(input logic [7:0] b, input logic eos, input logic typed,
                               input int typed_n, input logic [31:0] typed_chars,
                               input logic typed_err);
      rsp_item_type r [4];
      int        n;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      n = predict_codec(b, eos, r);
      if (typed) begin
         n = typed_n;
         for (int k = 0; k < n; k++)
            r[k] = '{typed_err ? 8'h00 : typed_chars[8*k +: 8], k == n - 1, typed_err};
      end
      for (int k = 0; k < n; k++) pending_bytes.push_back(r[k]);
   endtask

   task automatic send_decode_token(inout int sent);
      int         pick;
      int         len;
      int         eos_pos;
      logic [7:0] seq [4];
      pick    = $urandom_range(0, 99);
      eos_pos = -1;
      if (pick < 35) begin
         seq[0] = 8'($urandom_range(1, 255));
         if (seq[0] == CH_BACKSLASH) seq[0] = CH_DQUOTE;
         len = 1;
      end else if (pick < 50) begin
         seq[0] = CH_BACKSLASH;
         seq[1] = CH_BACKSLASH;
         len = 2;
      end else if (pick < 85) begin
         seq[0] = CH_BACKSLASH;
         seq[1] = pick_digit(3);
         seq[2] = pick_digit(7);
         seq[3] = pick_digit(7);
         if ($urandom_range(0, 9) == 0) seq[$urandom_range(2, 3)] = 8'($urandom_range(0, 255));
         len = 4;
      end else if (pick < 90) begin
         seq[0] = CH_NUL;
         len = 1;
      end else begin
         seq[0] = CH_BACKSLASH;
         seq[1] = 8'($urandom_range(0, 255));
         len = 2;
      end
      if ($urandom_range(0, 7) == 0) eos_pos = len - 1;
      else if ($urandom_range(0, 15) == 0) eos_pos = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) send_request(seq[k], k == eos_pos, 1'b0, 0, '0, 1'b0);
      sent += len;
   endtask

   // drain, let trailing no-response requests settle, then write mode
   task automatic set_codec_mode(input logic m);
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= {31'd0, m};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_mode  = m;
      esc_phase = PH_IDLE;
      part_val  = '0;
   endtask

   initial begin
      wait (pressure_go);
      @(posedge clock);
      pressure_hold <= 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      pressure_hold <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected response: expected none, got data %h last %b err %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            fail_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("%0t: data mismatch: expected %h, got %h", $time, want.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last mismatch: expected %b, got %b", $time, want.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser !== want.err) begin
               $display("%0t: error mismatch: expected %b, got %b", $time, want.err, rsp_tuser);
               fail_count++;
            end
         end
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !pressure_hold;
      end
   end

   initial begin
      dir_row_type row;
      int       sent;
      int       wait_cnt;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_codec_mode(MODE_ENCODE);

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = dir_tab[i];
         if (row.mode != cfg_mode) set_codec_mode(row.mode);
         send_request(row.data, row.eos, row.typed, int'(row.cnt), row.chars, row.err);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == RAND_PHASES - 1) idle_on = 1'b0;
         set_codec_mode((p % 2 == 0) ? MODE_DECODE : MODE_ENCODE);
         if (p == 1) pressure_go = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (cfg_mode == MODE_DECODE) begin
               send_decode_token(sent);
            end else begin
               send_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                            1'b0, 0, '0, 1'b0);
               sent++;
            end
         end
      end

      req_tvalid <= 1'b0;
      wait_cnt = 0;
      while (pending_bytes.size() != 0 && wait_cnt < 5000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, pending_bytes.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
